/* rtl/mfc_pkg.sv */
`default_nettype none

package mfc_pkg;

  localparam int unsigned HdrBytes  = 10;
  localparam int unsigned CountW    = 17;
  localparam int unsigned WordW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned OutDataW  = 48;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // configuration register indexes
  typedef enum logic [CfgAddrW-1:0] {
    REG_MAGIC   = 2'd0,
    REG_RD_RESP = 2'd1,
    REG_WR_REQ  = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_MAGIC      = 3'd2,
    ST_LEN_SMALL  = 3'd3,
    ST_LEN_DIFF   = 3'd4,
    ST_FUNC_DIFF  = 3'd5,
    ST_SIZE_DIFF  = 3'd6,
    ST_UNEXP_DATA = 3'd7
  } status_e;

  typedef struct packed {
    logic [WordW-1:0] magic;
    logic [WordW-1:0] rd_code;
    logic [WordW-1:0] wr_code;
  } cfg_t;

  typedef struct packed {
    logic [WordW-1:0] func;
    logic [WordW-1:0] magic;
    logic [WordW-1:0] length;
    logic [WordW-1:0] func_copy;
    logic [WordW-1:0] size;
  } hdr_t;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             payload_valid;
    logic             frame_done;
    status_e          status;
    logic [WordW-1:0] func_code;
    logic [WordW-1:0] data_size;
  } res_t;

endpackage

`default_nettype wire

/* rtl/mfc_frame.sv */
`default_nettype none

// byte counter and header capture for the frame in progress
module mfc_frame (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [mfc_pkg::ByteW-1:0]     byte_i,
  input  wire logic                          last_i,
  output mfc_pkg::hdr_t                      hdr_o,
  output logic      [mfc_pkg::CountW-1:0]    count_o,
  output logic                               payload_o
);

  logic [mfc_pkg::CountW-1:0] count_q, count_d;
  mfc_pkg::hdr_t              hdr_q, hdr_d;
  logic [2:0]                 word_sel;

  assign payload_o = (count_q >= mfc_pkg::CountW'(mfc_pkg::HdrBytes));
  assign word_sel  = count_q[3:1];

  // header words with the current byte merged in
  always_comb begin
    hdr_o = hdr_q;
    if (!payload_o) begin
      case (word_sel)
        3'd0: begin
          if (count_q[0]) hdr_o.func[15:8] = byte_i;
          else            hdr_o.func[7:0]  = byte_i;
        end
        3'd1: begin
          if (count_q[0]) hdr_o.magic[15:8] = byte_i;
          else            hdr_o.magic[7:0]  = byte_i;
        end
        3'd2: begin
          if (count_q[0]) hdr_o.length[15:8] = byte_i;
          else            hdr_o.length[7:0]  = byte_i;
        end
        3'd3: begin
          if (count_q[0]) hdr_o.func_copy[15:8] = byte_i;
          else            hdr_o.func_copy[7:0]  = byte_i;
        end
        default: begin
          if (count_q[0]) hdr_o.size[15:8] = byte_i;
          else            hdr_o.size[7:0]  = byte_i;
        end
      endcase
    end
  end

  assign count_o = (count_q == mfc_pkg::CountMax) ? count_q
                                                  : count_q + mfc_pkg::CountW'(1);

  always_comb begin
    count_d = count_q;
    hdr_d   = hdr_q;
    if (accept_i) begin
      if (last_i) begin
        count_d = '0;
        hdr_d   = '0;
      end else begin
        count_d = count_o;
        hdr_d   = hdr_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      hdr_q   <= '0;
    end else begin
      count_q <= count_d;
      hdr_q   <= hdr_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/mfc_verdict.sv */
`default_nettype none

// ordered frame checks, first failing check wins
module mfc_verdict (
  input  wire mfc_pkg::cfg_t                 cfg_i,
  input  wire mfc_pkg::hdr_t                 hdr_i,
  input  wire logic [mfc_pkg::CountW-1:0]    count_i,
  output mfc_pkg::status_e                   status_o
);

  logic [mfc_pkg::WordW-1:0] extra;
  logic                      carries;

  assign extra   = hdr_i.length - mfc_pkg::WordW'(mfc_pkg::HdrBytes);
  assign carries = (hdr_i.func == cfg_i.rd_code) || (hdr_i.func == cfg_i.wr_code);

  always_comb begin
    if (count_i < mfc_pkg::CountW'(mfc_pkg::HdrBytes)) begin
      status_o = mfc_pkg::ST_SHORT;
    end else if (hdr_i.magic != cfg_i.magic) begin
      status_o = mfc_pkg::ST_MAGIC;
    end else if (hdr_i.length < mfc_pkg::WordW'(mfc_pkg::HdrBytes)) begin
      status_o = mfc_pkg::ST_LEN_SMALL;
    end else if ({1'b0, hdr_i.length} != count_i) begin
      status_o = mfc_pkg::ST_LEN_DIFF;
    end else if (hdr_i.func != hdr_i.func_copy) begin
      status_o = mfc_pkg::ST_FUNC_DIFF;
    end else if (carries && (hdr_i.size != extra)) begin
      status_o = mfc_pkg::ST_SIZE_DIFF;
    end else if (!carries && (extra != '0)) begin
      status_o = mfc_pkg::ST_UNEXP_DATA;
    end else begin
      status_o = mfc_pkg::ST_OK;
    end
  end

endmodule

`default_nettype wire

/* rtl/message_frame_checker.sv */
`default_nettype none

// channel   dir  data                                      side bits
// s_axis    in   tdata[7:0] in_byte                        tlast frame_end
// m_axis    out  tdata[7:0] payload_byte, [10:8] status,   tlast frame_done,
//                [26:11] func_code, [42:27] data_size      tuser payload_valid
// cfg       in   cfg_addr_i register index, cfg_wdata_i    write on cfg_we_i
//
// one byte per cycle while s_tready is high; the result for a request is registered
// header bytes other than the last give no result, payload bytes and the
// last byte give one
// a two-entry output buffer (result register plus skid) lets input run on
// while a result waits; s_tready drops only when both entries are full
// reset clears the frame state and the configuration registers to zero
module message_frame_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [mfc_pkg::ByteW-1:0]         s_tdata,   // [7:0] in_byte
  input  wire logic                              s_tlast,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // [7:0] payload_byte, [10:8] status, [26:11] func_code, [42:27] data_size
  output logic [mfc_pkg::OutDataW-1:0]           m_tdata,
  output logic                                   m_tuser,   // [0] payload_valid
  output logic                                   m_tlast,
  input  wire logic                              cfg_we_i,
  input  wire logic [mfc_pkg::CfgAddrW-1:0]      cfg_addr_i,
  input  wire logic [mfc_pkg::WordW-1:0]         cfg_wdata_i
);

  mfc_pkg::cfg_t              cfg_q;
  mfc_pkg::hdr_t              hdr;
  logic [mfc_pkg::CountW-1:0] count;
  logic                       payload;
  mfc_pkg::status_e           status;
  mfc_pkg::res_t              res;
  logic                       accept, push, pop;

  mfc_pkg::res_t out_q, out_d, skid_q, skid_d;
  logic          out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (mfc_pkg::reg_idx_e'(cfg_addr_i))
        mfc_pkg::REG_MAGIC:   cfg_q.magic   <= cfg_wdata_i;
        mfc_pkg::REG_RD_RESP: cfg_q.rd_code <= cfg_wdata_i;
        mfc_pkg::REG_WR_REQ:  cfg_q.wr_code <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign s_tready = !skid_valid_q;
  assign accept   = s_tvalid && s_tready;

  mfc_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .byte_i    (s_tdata),
    .last_i    (s_tlast),
    .hdr_o     (hdr),
    .count_o   (count),
    .payload_o (payload)
  );

  mfc_verdict u_verdict (
    .cfg_i    (cfg_q),
    .hdr_i    (hdr),
    .count_i  (count),
    .status_o (status)
  );

  always_comb begin
    res.payload_byte  = payload ? s_tdata : '0;
    res.payload_valid = payload;
    res.frame_done    = s_tlast;
    res.status        = s_tlast ? status : mfc_pkg::ST_OK;
    res.func_code     = '0;
    res.data_size     = '0;
    if (s_tlast && (status != mfc_pkg::ST_SHORT)) begin
      res.func_code = hdr.func;
      res.data_size = hdr.size;
    end
  end

  assign push = accept && (payload || s_tlast);
  assign pop  = out_valid_q && m_tready;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_valid_q && !pop) begin
      if (push) begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (skid_valid_q) begin
      out_d        = skid_q;
      out_valid_d  = 1'b1;
      skid_valid_d = 1'b0;
    end else begin
      out_d       = res;
      out_valid_d = push;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_tvalid = out_valid_q;
  assign m_tlast  = out_q.frame_done;
  assign m_tuser  = out_q.payload_valid;
  assign m_tdata  = {5'd0, out_q.data_size, out_q.func_code, out_q.status,
                     out_q.payload_byte};

  // skid entry only fills behind a held result
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty result register");

  // results that do not end a frame carry payload and no verdict
  a_mid_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.frame_done) |->
      (out_q.payload_valid && out_q.status == mfc_pkg::ST_OK &&
       out_q.func_code == '0 && out_q.data_size == '0))
    else $error("mid-frame result with verdict fields set");

  // short frames report no header words and no payload
  a_short_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == mfc_pkg::ST_SHORT) |->
      (out_q.func_code == '0 && out_q.data_size == '0 && !out_q.payload_valid))
    else $error("short frame result carries header words or payload");

  // a full buffer blocks new requests in the next cycle unless drained
  a_full_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !m_tready) |=> !s_tready)
    else $error("request accepted while output buffer full");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;
  localparam int SettleCycles = 4;

  typedef struct packed {
    logic [7:0]        pbyte;
    logic              pvalid;
    logic              done;
    mfc_pkg::status_e  status;
    logic [15:0]       func;
    logic [15:0]       size;
  } frame_res_t;

  // one byte request; typed rows carry their own expected result
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    frame_res_t res;
  } step_row_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;        // [7:0] in_byte
  logic        s_tlast = 1'b0;      // frame_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;             // [7:0] payload_byte, [10:8] status, [26:11] func_code,
                                    // [42:27] data_size
  logic        m_tuser;             // [0] payload_valid
  logic        m_tlast;             // frame_done
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  message_frame_checker u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // shadow of the checker state and its registers
  logic [16:0] frm_count = '0;
  logic [15:0] hdr_func = '0, hdr_magic = '0, hdr_len = '0, hdr_func_copy = '0;
  logic [15:0] hdr_size = '0;
  logic [15:0] cfg_magic = '0, cfg_rd_code = '0, cfg_wr_code = '0;

  frame_res_t awaited_out_q[$];
  step_row_t  driven_bytes_q[$];
  logic [7:0] frame_bytes_q[$];

  int send_idle_pct = 0;
  int rcv_idle_pct = 0;
  int bytes_sent = 0;
  int mismatch_count = 0;
  int stall_cycles = 0;

  step_row_t dir_rows [24] = '{
    '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, mfc_pkg::ST_SHORT, 16'h0000, 16'h0000}},
    '{8'h03, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h5A, 1'b0, 1'b0, '0},
    '{8'hA5, 1'b0, 1'b0, '0},
    '{8'h0C, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h03, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, mfc_pkg::ST_OK, 16'h0000, 16'h0000}},
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, mfc_pkg::ST_OK, 16'h0003, 16'h0002}},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, mfc_pkg::ST_MAGIC, 16'hFFFF, 16'hFFFF}},
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, mfc_pkg::ST_SHORT, 16'h0000, 16'h0000}}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic mfc_pkg::status_e frame_verdict(input logic [16:0] n);
    logic [16:0] extra;
    bit          carries;
    if (n < mfc_pkg::HdrBytes) return mfc_pkg::ST_SHORT;
    if (hdr_magic != cfg_magic) return mfc_pkg::ST_MAGIC;
    if (hdr_len < mfc_pkg::HdrBytes) return mfc_pkg::ST_LEN_SMALL;
    if ({1'b0, hdr_len} != n) return mfc_pkg::ST_LEN_DIFF;
    if (hdr_func != hdr_func_copy) return mfc_pkg::ST_FUNC_DIFF;
    extra = {1'b0, hdr_len} - 17'(mfc_pkg::HdrBytes);
    carries = (hdr_func == cfg_rd_code) || (hdr_func == cfg_wr_code);
    if (carries) begin
      if ({1'b0, hdr_size} != extra) return mfc_pkg::ST_SIZE_DIFF;
    end else if (extra != 0) begin
      return mfc_pkg::ST_UNEXP_DATA;
    end
    return mfc_pkg::ST_OK;
  endfunction

  task automatic track_frame_byte(input logic [7:0] b, input logic last,
                                  output bit has_res, output frame_res_t res);
    logic [16:0]      pos;
    logic [16:0]      n;
    bit               payload;
    mfc_pkg::status_e st;
    pos = frm_count;
    payload = (pos >= mfc_pkg::HdrBytes);
    if (!payload) begin
      case (pos[3:1])
        3'd0: if (pos[0]) hdr_func[15:8] = b; else hdr_func[7:0] = b;
        3'd1: if (pos[0]) hdr_magic[15:8] = b; else hdr_magic[7:0] = b;
        3'd2: if (pos[0]) hdr_len[15:8] = b; else hdr_len[7:0] = b;
        3'd3: if (pos[0]) hdr_func_copy[15:8] = b; else hdr_func_copy[7:0] = b;
        default: if (pos[0]) hdr_size[15:8] = b; else hdr_size[7:0] = b;
      endcase
    end
    n = (pos < mfc_pkg::CountMax) ? pos + 17'd1 : mfc_pkg::CountMax;
    frm_count = n;
    has_res = payload || last;
    res = '0;
    res.pbyte = payload ? b : 8'h00;
    res.pvalid = payload;
    res.done = last;
    res.status = mfc_pkg::ST_OK;
    if (last) begin
      st = frame_verdict(n);
      res.status = st;
      if (st != mfc_pkg::ST_SHORT) begin
        res.func = hdr_func;
        res.size = hdr_size;
      end
      frm_count = '0;
      hdr_func = '0;
      hdr_magic = '0;
      hdr_len = '0;
      hdr_func_copy = '0;
      hdr_size = '0;
    end
  endtask

  // request side predicts, response side compares, both on the same edge
  always @(posedge clk_i) begin : scoreboard
    step_row_t  row;
    frame_res_t pred, want, got;
    bit         has_res;
    if (rst_ni && s_tvalid && s_tready) begin
      row = driven_bytes_q.pop_front();
      track_frame_byte(s_tdata, s_tlast, has_res, pred);
      if (row.typed) pred = row.res;
      if (has_res) awaited_out_q = {awaited_out_q, pred};
    end
    if (rst_ni && m_tvalid && m_tready) begin
      got.pbyte = m_tdata[7:0];
      got.status = mfc_pkg::status_e'(m_tdata[10:8]);
      got.func = m_tdata[26:11];
      got.size = m_tdata[42:27];
      got.pvalid = m_tuser;
      got.done = m_tlast;
      if (awaited_out_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: byte %h pv %b done %b st %0d func %h size %h",
                   got.pbyte, got.pvalid, got.done, got.status, got.func, got.size);
      end else begin
        want = awaited_out_q.pop_front();
        if (got.pbyte !== want.pbyte || got.pvalid !== want.pvalid ||
            got.done !== want.done || got.status !== want.status ||
            got.func !== want.func || got.size !== want.size ||
            m_tdata[47:43] !== 5'd0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch exp: byte %h pv %b done %b st %0d func %h size %h",
                     want.pbyte, want.pvalid, want.done, want.status, want.func,
                     want.size);
            $display("         got: byte %h pv %b done %b st %0d func %h size %h pad %h",
                     got.pbyte, got.pvalid, got.done, got.status, got.func, got.size,
                     m_tdata[47:43]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == StallLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic load_config(input logic [15:0] magic, input logic [15:0] rd_code,
                             input logic [15:0] wr_code);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= mfc_pkg::REG_MAGIC;
    cfg_wdata_i <= magic;
    @(posedge clk_i);
    cfg_addr_i <= mfc_pkg::REG_RD_RESP;
    cfg_wdata_i <= rd_code;
    @(posedge clk_i);
    cfg_addr_i <= mfc_pkg::REG_WR_REQ;
    cfg_wdata_i <= wr_code;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_magic = magic;
    cfg_rd_code = rd_code;
    cfg_wr_code = wr_code;
  endtask

  task automatic send_row(input step_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= row.data;
    s_tlast <= row.last;
    driven_bytes_q = {driven_bytes_q, row};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame();
    step_row_t row;
    while (frame_bytes_q.size() != 0) begin
      row = '0;
      row.data = frame_bytes_q.pop_front();
      row.last = (frame_bytes_q.size() == 0);
      send_row(row);
    end
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (awaited_out_q.size() != 0 || driven_bytes_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic push_header(input logic [15:0] f, input logic [15:0] mg,
                             input logic [15:0] len, input logic [15:0] fc,
                             input logic [15:0] sz);
    logic [15:0] words [5];
    words = '{f, mg, len, fc, sz};
    for (int i = 0; i < 10; i++)
      frame_bytes_q = {frame_bytes_q,
                       (i[0] ? words[i >> 1][15:8] : words[i >> 1][7:0])};
  endtask

  // noise or header-built frames, some with one header field or the byte count broken
  task automatic build_random_frame();
    int          kind, plen, nbytes;
    logic [15:0] w_func, w_magic, w_len, w_copy, w_size;
    frame_bytes_q.delete();
    kind = $urandom_range(99);
    if (kind < 5) begin
      nbytes = $urandom_range(24, 1);
      repeat (nbytes) frame_bytes_q = {frame_bytes_q, 8'($urandom)};
      return;
    end
    plen = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
    case ($urandom_range(2))
      0: w_func = cfg_rd_code;
      1: w_func = cfg_wr_code;
      default: w_func = 16'($urandom);
    endcase
    if (w_func != cfg_rd_code && w_func != cfg_wr_code && $urandom_range(1)) plen = 0;
    w_magic = cfg_magic;
    w_len = 16'(10 + plen);
    w_copy = w_func;
    w_size = $urandom_range(3) == 0 ? 16'($urandom) : 16'(plen);
    nbytes = 10 + plen;
    if (kind < 11) w_magic = w_magic ^ (16'd1 << $urandom_range(15));
    else if (kind < 17) w_len = 16'($urandom_range(9));
    else if (kind < 23) begin
      nbytes = 10 + $urandom_range(12);
      if (nbytes == 10 + plen) nbytes++;
    end
    else if (kind < 29) w_copy = w_copy ^ (16'd1 << $urandom_range(15));
    else if (kind < 35) w_size = w_size ^ (16'd1 << $urandom_range(15));
    else if (kind < 41) nbytes = $urandom_range(9, 1);
    push_header(w_func, w_magic, w_len, w_copy, w_size);
    while (frame_bytes_q.size() < nbytes) frame_bytes_q = {frame_bytes_q, 8'($urandom)};
    while (frame_bytes_q.size() > nbytes) void'(frame_bytes_q.pop_back());
  endtask

  initial begin : stimulus
    int          goal;
    logic [15:0] m, rd, wr;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 26;
    rcv_idle_pct = 85;
    load_config(16'hA55A, 16'h0003, 16'h0010);
    foreach (dir_rows[i]) send_row(dir_rows[i]);
    wait_drain();

    for (int seg = 0; seg < 9; seg++) begin
      case (seg / 3)
        0: begin send_idle_pct = 26; rcv_idle_pct = 85; end
        1: begin send_idle_pct = 85; rcv_idle_pct = 26; end
        default: begin send_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      m = 16'($urandom);
      rd = 16'($urandom);
      wr = 16'($urandom);
      case (seg)
        0: begin m = '0; rd = '0; wr = '0; end
        1: begin m = 16'hFFFF; rd = 16'hFFFF; wr = 16'hFFFF; end
        3: begin m = 16'hFFFF; rd = '0; wr = 16'hFFFF; end
        4: wr = rd;
        default: ;
      endcase
      load_config(m, rd, wr);
      goal = bytes_sent + 108;
      while (bytes_sent < goal) begin
        build_random_frame();
        send_frame();
      end
      wait_drain();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_out_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/mfc_pkg.sv
rtl/mfc_frame.sv
rtl/mfc_verdict.sv
rtl/message_frame_checker.sv
tb/tb_top.sv
